@@ rtl/assert_macros.svh @@
// Assertion macros shared by the allocator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ rtl/thnf_pkg.sv @@
// Types and constants for the two-heap next-fit allocator.
// No dependencies; used by thnf_core and the top level.
package thnf_pkg;

  localparam int SIZE_W  = 18;
  localparam int LEN_W   = 17;
  localparam int REQ_W   = 16;
  localparam int TAG_BYTES    = 16;
  localparam int MAIN_GRANULE = 5;

  typedef enum logic [2:0] {
    OP_INIT    = 3'd0,
    OP_ALLOC   = 3'd1,
    OP_FREE    = 3'd2,
    OP_COLLECT = 3'd3,
    OP_QUERY   = 3'd4,
    OP_CHECK   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    TS_FREE  = 2'd0,
    TS_USED  = 2'd1,
    TS_ALLOC = 2'd2
  } tag_status_t;

  typedef enum logic {
    CFG_FIRST  = 1'b0,
    CFG_SECOND = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    RET_FREE    = 1'b0,
    RET_COLLECT = 1'b1
  } ret_t;

  typedef enum logic [4:0] {
    SQ_IDLE, SQ_CLR, SQ_INIT_S0, SQ_INIT_M0, SQ_INIT_S1, SQ_INIT_M1, SQ_SNAP,
    SQ_A_RD, SQ_A_NODE, SQ_A_SPLIT, SQ_A_RA, SQ_A_WA, SQ_A_WT,
    SQ_F_RD, SQ_F_CHK,
    SQ_S_HEAD, SQ_S_NODE, SQ_S_END,
    SQ_C_HEAD, SQ_C_NODE, SQ_C_CONT,
    SQ_R_START, SQ_R_PRD, SQ_R_PREV, SQ_R_NX, SQ_R_NXD, SQ_R_END,
    SQ_J_WA, SQ_J_RN, SQ_J_WN, SQ_J_WB,
    SQ_DONE
  } seq_state_t;

  typedef struct packed {
    logic              collected;
    logic [SIZE_W-1:0] free_total;
    logic [15:0]       grant_offset;
    logic              grant_ok;
  } res_t;

endpackage

@@ rtl/thnf_tag_ram.sv @@
// Single-port tag store with registered read data.
// No dependencies; instantiated by the allocator top level.
module thnf_tag_ram #(
  parameter int AW = 15,
  parameter int DW = 49
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/thnf_core.sv @@
// Sequencer and shared datapath of the allocator: walks tag chains one tag a cycle.
// Depends on thnf_pkg and assert_macros.svh; drives the port of thnf_tag_ram.
`include "assert_macros.svh"
module thnf_core #(
  parameter int HEAP_BYTES = 65536,
  parameter int SPLIT_MIN  = 64,
  parameter int GW         = $clog2(HEAP_BYTES / 4),
  parameter int TW         = 3 + 2 * GW + thnf_pkg::SIZE_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_op,
  input  logic [1:0]                    in_mask,
  input  logic [thnf_pkg::REQ_W-1:0]    in_req,
  input  logic [15:0]                   in_rel,
  input  logic [thnf_pkg::LEN_W-1:0]    len_first,
  input  logic [thnf_pkg::LEN_W-1:0]    len_second,
  output logic                          res_valid,
  input  logic                          res_ready,
  output thnf_pkg::res_t                res,
  output logic                          mem_we,
  output logic [GW:0]                   mem_addr,
  output logic [TW-1:0]                 mem_wdata,
  input  logic [TW-1:0]                 mem_rdata
);

  localparam int GRANULES = HEAP_BYTES / 4;
  localparam int SW = thnf_pkg::SIZE_W;
  localparam logic [18:0] HEAP_MAX = 19'(HEAP_BYTES);
  localparam logic [GW-1:0] MAIN_G = GW'(thnf_pkg::MAIN_GRANULE);

  typedef struct packed {
    logic                  live;
    thnf_pkg::tag_status_t status;
    logic [GW-1:0]         prev;
    logic [GW-1:0]         next;
    logic [SW-1:0]         size;
  } tag_t;

  function automatic logic [18:0] clamp_len(input logic [thnf_pkg::LEN_W-1:0] v);
    logic [18:0] r;
    if (v < 17'd256) begin
      r = 19'd256;
    end else if (19'(v) > HEAP_MAX) begin
      r = HEAP_MAX;
    end else begin
      r = 19'(v);
    end
    return r;
  endfunction

  thnf_pkg::seq_state_t state, state_next;
  thnf_pkg::ret_t ret;

  logic [GW-1:0] cg, og, endg, wnxt, rover_first, rover_second, rover_h;
  logic [GW-1:0] end_c, nb, ag, bg;
  tag_t ct, ot, rd, wt, at, bt, merged, sent_t, main_t;
  logic [SW-1:0] need, need_c, sum, snap, rem, sum_add, tot;
  logic [17:0] nb_sum;
  logic [15:0] off, off_c, relm, relg;
  logic [18:0] len0, len1;
  logic [19:0] snap_c;
  logic [GW:0] clr_cnt;
  logic h, more, first, jdir, chk, ok, coll;
  logic fit, split, rel_ok, cnt_last;

  assign rd       = tag_t'(mem_rdata);
  assign rover_h  = h ? rover_second : rover_first;
  assign end_c    = first ? rd.prev : endg;
  assign fit      = (rd.status == thnf_pkg::TS_FREE) && (rd.size >= need);
  assign rem      = ct.size - need;
  assign split    = rem > SW'(SPLIT_MIN);
  assign nb_sum   = 18'(cg) + (need >> 2);
  assign nb       = nb_sum[GW-1:0];
  assign ag       = jdir ? cg : og;
  assign bg       = jdir ? og : cg;
  assign at       = jdir ? ct : ot;
  assign bt       = jdir ? ot : ct;
  assign sum_add  = sum + rd.size - SW'(thnf_pkg::TAG_BYTES);
  assign off_c    = 16'((18'(cg) << 2) + 18'(thnf_pkg::TAG_BYTES));
  assign need_c   = (SW'(in_req) + SW'(19)) & ~SW'(3);
  assign relm     = in_rel - 16'(thnf_pkg::TAG_BYTES);
  assign relg     = relm >> 2;
  assign rel_ok   = (in_rel >= 16'(thnf_pkg::TAG_BYTES)) && (in_rel[1:0] == 2'b00)
                    && (17'(relg) < 17'(GRANULES));
  assign cnt_last = &clr_cnt;
  assign len0     = clamp_len(len_first);
  assign len1     = clamp_len(len_second);
  assign snap_c   = 20'(len0) + 20'(len1) - 20'd72;

  always_comb begin
    merged      = at;
    merged.size = at.size + bt.size;
    merged.next = bt.next;
    sent_t        = '0;
    sent_t.live   = 1'b1;
    sent_t.status = thnf_pkg::TS_USED;
    sent_t.prev   = MAIN_G;
    sent_t.next   = MAIN_G;
    main_t        = '0;
    main_t.live   = 1'b1;
    main_t.status = thnf_pkg::TS_FREE;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      thnf_pkg::SQ_IDLE: begin
        if (in_valid) begin
          unique case (thnf_pkg::op_t'(in_op))
            thnf_pkg::OP_INIT:    state_next = thnf_pkg::SQ_CLR;
            thnf_pkg::OP_ALLOC:   state_next = thnf_pkg::SQ_A_RD;
            thnf_pkg::OP_FREE:    state_next = rel_ok ? thnf_pkg::SQ_F_RD : thnf_pkg::SQ_DONE;
            thnf_pkg::OP_COLLECT: state_next = (in_mask == 2'b00) ? thnf_pkg::SQ_DONE
                                                                  : thnf_pkg::SQ_C_HEAD;
            thnf_pkg::OP_QUERY:   state_next = (in_mask == 2'b00) ? thnf_pkg::SQ_DONE
                                                                  : thnf_pkg::SQ_S_HEAD;
            thnf_pkg::OP_CHECK:   state_next = thnf_pkg::SQ_S_HEAD;
            default:              state_next = thnf_pkg::SQ_DONE;
          endcase
        end
      end
      thnf_pkg::SQ_CLR:     if (cnt_last) state_next = thnf_pkg::SQ_INIT_S0;
      thnf_pkg::SQ_INIT_S0: state_next = thnf_pkg::SQ_INIT_M0;
      thnf_pkg::SQ_INIT_M0: state_next = thnf_pkg::SQ_INIT_S1;
      thnf_pkg::SQ_INIT_S1: state_next = thnf_pkg::SQ_INIT_M1;
      thnf_pkg::SQ_INIT_M1: state_next = thnf_pkg::SQ_SNAP;
      thnf_pkg::SQ_SNAP:    state_next = thnf_pkg::SQ_DONE;
      thnf_pkg::SQ_A_RD:    state_next = thnf_pkg::SQ_A_NODE;
      thnf_pkg::SQ_A_NODE: begin
        if (fit) begin
          state_next = thnf_pkg::SQ_A_SPLIT;
        end else if (cg == end_c) begin
          state_next = thnf_pkg::SQ_DONE;
        end
      end
      thnf_pkg::SQ_A_SPLIT: state_next = split ? thnf_pkg::SQ_A_RA : thnf_pkg::SQ_DONE;
      thnf_pkg::SQ_A_RA:    state_next = thnf_pkg::SQ_A_WA;
      thnf_pkg::SQ_A_WA:    state_next = thnf_pkg::SQ_A_WT;
      thnf_pkg::SQ_A_WT:    state_next = thnf_pkg::SQ_DONE;
      thnf_pkg::SQ_F_RD:    state_next = thnf_pkg::SQ_F_CHK;
      thnf_pkg::SQ_F_CHK: begin
        state_next = (rd.live && rd.status == thnf_pkg::TS_ALLOC) ? thnf_pkg::SQ_R_START
                                                                  : thnf_pkg::SQ_DONE;
      end
      thnf_pkg::SQ_S_HEAD:  state_next = thnf_pkg::SQ_S_NODE;
      thnf_pkg::SQ_S_NODE: begin
        if (rd.next == '0) begin
          state_next = (more && !h) ? thnf_pkg::SQ_S_HEAD : thnf_pkg::SQ_S_END;
        end
      end
      thnf_pkg::SQ_S_END: begin
        state_next = (chk && sum != snap) ? thnf_pkg::SQ_C_HEAD : thnf_pkg::SQ_DONE;
      end
      thnf_pkg::SQ_C_HEAD:  state_next = thnf_pkg::SQ_C_NODE;
      thnf_pkg::SQ_C_NODE: begin
        if (rd.status == thnf_pkg::TS_ALLOC) begin
          state_next = thnf_pkg::SQ_R_START;
        end else if (rd.next == '0) begin
          state_next = (more && !h) ? thnf_pkg::SQ_C_HEAD : thnf_pkg::SQ_DONE;
        end
      end
      thnf_pkg::SQ_C_CONT: begin
        if (wnxt == '0) begin
          state_next = (more && !h) ? thnf_pkg::SQ_C_HEAD : thnf_pkg::SQ_DONE;
        end else begin
          state_next = thnf_pkg::SQ_C_NODE;
        end
      end
      thnf_pkg::SQ_R_START: state_next = thnf_pkg::SQ_R_PRD;
      thnf_pkg::SQ_R_PRD:   state_next = (ct.prev != cg) ? thnf_pkg::SQ_R_PREV : thnf_pkg::SQ_R_NX;
      thnf_pkg::SQ_R_PREV: begin
        state_next = (rd.status == thnf_pkg::TS_FREE) ? thnf_pkg::SQ_J_WA : thnf_pkg::SQ_R_NX;
      end
      thnf_pkg::SQ_R_NX:    state_next = (ct.next != cg) ? thnf_pkg::SQ_R_NXD : thnf_pkg::SQ_R_END;
      thnf_pkg::SQ_R_NXD: begin
        state_next = (rd.status == thnf_pkg::TS_FREE) ? thnf_pkg::SQ_J_WA : thnf_pkg::SQ_R_END;
      end
      thnf_pkg::SQ_R_END: begin
        state_next = (ret == thnf_pkg::RET_COLLECT) ? thnf_pkg::SQ_C_CONT : thnf_pkg::SQ_DONE;
      end
      thnf_pkg::SQ_J_WA:    state_next = thnf_pkg::SQ_J_RN;
      thnf_pkg::SQ_J_RN:    state_next = thnf_pkg::SQ_J_WN;
      thnf_pkg::SQ_J_WN:    state_next = thnf_pkg::SQ_J_WB;
      thnf_pkg::SQ_J_WB:    state_next = jdir ? thnf_pkg::SQ_R_END : thnf_pkg::SQ_R_NX;
      thnf_pkg::SQ_DONE:    if (res_ready) state_next = thnf_pkg::SQ_IDLE;
      default:              state_next = thnf_pkg::SQ_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == thnf_pkg::SQ_IDLE);
    res_valid = (state == thnf_pkg::SQ_DONE);
    res.grant_ok     = ok;
    res.grant_offset = off;
    res.free_total   = tot;
    res.collected    = coll;
    mem_we   = 1'b0;
    mem_addr = {h, cg};
    wt       = ct;
    unique case (state)
      thnf_pkg::SQ_CLR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt;
        wt       = '0;
      end
      thnf_pkg::SQ_INIT_S0, thnf_pkg::SQ_INIT_S1: begin
        mem_we   = 1'b1;
        mem_addr = {state == thnf_pkg::SQ_INIT_S1, GW'(0)};
        wt       = sent_t;
      end
      thnf_pkg::SQ_INIT_M0, thnf_pkg::SQ_INIT_M1: begin
        mem_we   = 1'b1;
        mem_addr = {state == thnf_pkg::SQ_INIT_M1, MAIN_G};
        wt       = main_t;
        wt.size  = (state == thnf_pkg::SQ_INIT_M1) ? SW'(len1 - 19'd20) : SW'(len0 - 19'd20);
      end
      thnf_pkg::SQ_A_RD:    mem_addr = {h, rover_h};
      thnf_pkg::SQ_A_NODE, thnf_pkg::SQ_S_NODE, thnf_pkg::SQ_C_NODE: begin
        mem_addr = {h, rd.next};
      end
      thnf_pkg::SQ_A_SPLIT: begin
        mem_we = 1'b1;
        if (split) begin
          mem_addr  = {h, nb};
          wt.live   = 1'b1;
          wt.status = thnf_pkg::TS_FREE;
          wt.size   = rem;
          wt.prev   = cg;
          wt.next   = ct.next;
        end else begin
          wt.status = thnf_pkg::TS_ALLOC;
        end
      end
      thnf_pkg::SQ_A_RA:    mem_addr = {h, ct.next};
      thnf_pkg::SQ_A_WA: begin
        mem_we   = 1'b1;
        mem_addr = {h, ct.next};
        wt       = rd;
        wt.prev  = og;
      end
      thnf_pkg::SQ_A_WT: begin
        mem_we    = 1'b1;
        wt.next   = og;
        wt.size   = need;
        wt.status = thnf_pkg::TS_ALLOC;
      end
      thnf_pkg::SQ_S_HEAD, thnf_pkg::SQ_C_HEAD: mem_addr = {h, GW'(0)};
      thnf_pkg::SQ_C_CONT:  mem_addr = {h, wnxt};
      thnf_pkg::SQ_R_START: begin
        mem_we    = 1'b1;
        wt.status = thnf_pkg::TS_FREE;
      end
      thnf_pkg::SQ_R_PRD:   mem_addr = {h, ct.prev};
      thnf_pkg::SQ_R_NX:    mem_addr = {h, ct.next};
      thnf_pkg::SQ_J_WA: begin
        mem_we   = 1'b1;
        mem_addr = {h, ag};
        wt       = merged;
      end
      thnf_pkg::SQ_J_RN:    mem_addr = {h, ot.next};
      thnf_pkg::SQ_J_WN: begin
        mem_we   = 1'b1;
        mem_addr = {h, ot.next};
        wt       = rd;
        wt.prev  = cg;
      end
      thnf_pkg::SQ_J_WB: begin
        mem_we   = 1'b1;
        mem_addr = {h, og};
        wt       = ot;
        wt.live  = 1'b0;
      end
      default: ;
    endcase
    mem_wdata = wt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= thnf_pkg::SQ_IDLE;
      rover_first  <= MAIN_G;
      rover_second <= MAIN_G;
      snap         <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        thnf_pkg::SQ_IDLE: begin
          if (in_valid) begin
            ok      <= 1'b0;
            off     <= '0;
            tot     <= '0;
            coll    <= 1'b0;
            sum     <= '0;
            need    <= need_c;
            cg      <= relg[GW-1:0];
            clr_cnt <= '0;
            chk     <= (in_op == thnf_pkg::OP_CHECK);
            h       <= (in_op == thnf_pkg::OP_CHECK) ? 1'b0 : !in_mask[0];
            more    <= (in_op == thnf_pkg::OP_CHECK) || (in_mask == 2'b11);
          end
        end
        thnf_pkg::SQ_CLR:  clr_cnt <= clr_cnt + 1'b1;
        thnf_pkg::SQ_SNAP: begin
          snap         <= snap_c[SW-1:0];
          rover_first  <= MAIN_G;
          rover_second <= MAIN_G;
        end
        thnf_pkg::SQ_A_RD: begin
          cg    <= rover_h;
          first <= 1'b1;
        end
        thnf_pkg::SQ_A_NODE: begin
          endg  <= end_c;
          first <= 1'b0;
          if (fit) begin
            ct <= rd;
          end else begin
            cg <= rd.next;
          end
        end
        thnf_pkg::SQ_A_SPLIT: begin
          if (split) begin
            og <= nb;
          end else begin
            ok  <= 1'b1;
            off <= off_c;
            if (h) rover_second <= ct.next;
            else   rover_first  <= ct.next;
          end
        end
        thnf_pkg::SQ_A_WT: begin
          ok  <= 1'b1;
          off <= off_c;
          if (h) rover_second <= og;
          else   rover_first  <= og;
        end
        thnf_pkg::SQ_F_CHK: begin
          ct  <= rd;
          ret <= thnf_pkg::RET_FREE;
        end
        thnf_pkg::SQ_S_NODE: begin
          if (rd.status == thnf_pkg::TS_FREE && rd.size > SW'(thnf_pkg::TAG_BYTES)) begin
            sum <= sum_add;
          end
          if (rd.next == '0) begin
            if (more && !h) begin
              h    <= 1'b1;
              more <= 1'b0;
            end
          end
        end
        thnf_pkg::SQ_S_END: begin
          if (!chk) begin
            tot <= sum;
          end else if (sum != snap) begin
            coll <= 1'b1;
            h    <= 1'b0;
            more <= 1'b1;
          end
        end
        thnf_pkg::SQ_C_HEAD: cg <= '0;
        thnf_pkg::SQ_C_NODE: begin
          wnxt <= rd.next;
          if (rd.status == thnf_pkg::TS_ALLOC) begin
            ct  <= rd;
            ret <= thnf_pkg::RET_COLLECT;
          end else if (rd.next == '0) begin
            if (more && !h) begin
              h    <= 1'b1;
              more <= 1'b0;
            end
          end else begin
            cg <= rd.next;
          end
        end
        thnf_pkg::SQ_C_CONT: begin
          if (wnxt == '0) begin
            if (more && !h) begin
              h    <= 1'b1;
              more <= 1'b0;
            end
          end else begin
            cg <= wnxt;
          end
        end
        thnf_pkg::SQ_R_START: ct.status <= thnf_pkg::TS_FREE;
        thnf_pkg::SQ_R_PRD:   og <= ct.prev;
        thnf_pkg::SQ_R_PREV: begin
          ot   <= rd;
          jdir <= 1'b0;
        end
        thnf_pkg::SQ_R_NX:    og <= ct.next;
        thnf_pkg::SQ_R_NXD: begin
          ot   <= rd;
          jdir <= 1'b1;
        end
        thnf_pkg::SQ_J_WA: begin
          cg <= ag;
          ct <= merged;
          og <= bg;
          ot <= bt;
        end
        thnf_pkg::SQ_J_WB: begin
          if (h && rover_second == og) rover_second <= cg;
          if (!h && rover_first == og) rover_first  <= cg;
        end
        default: ;
      endcase
    end
  end

  `ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_valid && in_ready, state != thnf_pkg::SQ_IDLE, "accepted item left sequencer idle")
  `ASSERT_IMPLY(a_write_in_work, clk, rst, mem_we, state != thnf_pkg::SQ_IDLE && state != thnf_pkg::SQ_DONE, "tag write outside an operation")
  `ASSERT_IMPLY(a_collect_from_check, clk, rst, res_valid && res.collected, chk, "collect flag without check operation")

endmodule

@@ rtl/two_heap_next_fit_allocator.sv @@
// Two-heap next-fit allocator with boundary tags: top level, ports and result register.
// Depends on thnf_pkg, thnf_core and thnf_tag_ram.
//
// One operation is taken at a time over a single-port tag store that serves one tag
// read or write per cycle; allocate, query and collect walk the tag chains through that
// port. Init clears the whole store, then writes sentinel and main tags of each heap.
// Allocate visits blocks from the rover until one fits and marks it allocated; when it
// splits, it also writes the new free block and relinks the block after it. Free
// releases a live allocated block and merges it with free neighbours. A query sums
// the free bytes of the heaps it walks; collect releases every allocated block it
// visits; check and collect runs a query of both heaps and, on a mismatch, a collect of
// both. A finished result waits in the output register while the next item is taken.
module two_heap_next_fit_allocator #(
  parameter int HEAP_BYTES = 65536,
  parameter int SPLIT_MIN  = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,    // opcode, heap_mask, request_bytes, release_offset
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,    // grant_ok, grant_offset, free_total, collected
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int GW = $clog2(HEAP_BYTES / 4);
  localparam int TW = 3 + 2 * GW + thnf_pkg::SIZE_W;

  logic [thnf_pkg::LEN_W-1:0] first_heap_bytes, second_heap_bytes;
  logic                       res_valid, res_ready, mem_we;
  thnf_pkg::res_t             res;
  logic [GW:0]                mem_addr;
  logic [TW-1:0]              mem_wdata, mem_rdata;

  assign cfg_ready = 1'b1;
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_heap_bytes  <= 17'd32768;
      second_heap_bytes <= 17'd65536;
    end else if (cfg_valid) begin
      unique case (thnf_pkg::cfg_reg_t'(cfg_index))
        thnf_pkg::CFG_FIRST:  first_heap_bytes  <= cfg_data;
        thnf_pkg::CFG_SECOND: second_heap_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
    if (res_valid && res_ready) begin
      m_tdata <= {4'b0000, res};
    end
  end

  thnf_core #(
    .HEAP_BYTES (HEAP_BYTES),
    .SPLIT_MIN  (SPLIT_MIN),
    .GW         (GW),
    .TW         (TW)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_op      (s_tdata[2:0]),
    .in_mask    (s_tdata[4:3]),
    .in_req     (s_tdata[20:5]),
    .in_rel     (s_tdata[36:21]),
    .len_first  (first_heap_bytes),
    .len_second (second_heap_bytes),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_we     (mem_we),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .mem_rdata  (mem_rdata)
  );

  thnf_tag_ram #(
    .AW (GW + 1),
    .DW (TW)
  ) u_tags (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule
